>>> rtl/dvl_pkg.sv
// shared types, register codes and helpers for the directional vertex lighting core
package dvl_pkg;

  localparam int unsigned LaneW   = 16;
  localparam int unsigned NLanes  = 4;
  localparam int unsigned CfgW    = LaneW * NLanes;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned Depth   = 5;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgNormalOffset   = 3'd0,
    CfgLightDirection = 3'd1,
    CfgAmbientTerm    = 3'd2,
    CfgLitColor       = 3'd3,
    CfgIncidentShadow = 3'd4,
    CfgBackShade      = 3'd5,
    CfgTranslucent    = 3'd6
  } dvl_cfg_e;

  // facing factors handed to the shading lanes
  typedef struct packed {
    logic [LaneW-1:0] pos;  // max(s,0)
    logic [LaneW-1:0] neg;  // ~s when s is negative, else all ones
  } dvl_factor_t;

  // arithmetic shift right by 4, then clamp to 0..255
  function automatic logic [7:0] shift_clamp(input logic [LaneW-1:0] w);
    logic [7:0] r;
    if (w[LaneW-1]) begin
      r = 8'd0;
    end else if (w[LaneW-2:12] != '0) begin
      r = 8'hFF;
    end else begin
      r = w[11:4];
    end
    return r;
  endfunction

endpackage

>>> rtl/dvl_shade_lane.sv
// one shading lane: two signed high-half products, sum with ambient, clamp to a byte
module dvl_shade_lane (
  input  logic                       clk_i,
  input  dvl_pkg::dvl_factor_t       factor_i,
  input  logic [dvl_pkg::LaneW-1:0]  ambient_i,
  input  logic [dvl_pkg::LaneW-1:0]  coef_pos_i,
  input  logic [dvl_pkg::LaneW-1:0]  coef_neg_i,
  output logic [7:0]                 byte_o
);

  logic signed [2*dvl_pkg::LaneW-1:0] prod_pos, prod_neg;
  logic [dvl_pkg::LaneW-1:0] hi_pos_d, hi_pos_q, hi_neg_d, hi_neg_q;
  logic [dvl_pkg::LaneW-1:0] amb_q;
  logic [dvl_pkg::LaneW-1:0] total;
  logic [7:0] byte_d, byte_q;

  assign prod_pos = $signed(coef_pos_i) * $signed(factor_i.pos);
  assign prod_neg = $signed(coef_neg_i) * $signed(factor_i.neg);
  assign hi_pos_d = prod_pos[2*dvl_pkg::LaneW-1:dvl_pkg::LaneW];
  assign hi_neg_d = prod_neg[2*dvl_pkg::LaneW-1:dvl_pkg::LaneW];

  // product stage
  always_ff @(posedge clk_i) begin
    hi_pos_q <= hi_pos_d;
    hi_neg_q <= hi_neg_d;
    amb_q    <= ambient_i;
  end

  // wrapping 16-bit sum
  assign total  = amb_q + hi_pos_q + hi_neg_q;
  assign byte_d = dvl_pkg::shift_clamp(total);

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

>>> rtl/directional_vertex_lighting_core.sv
// top level of the directional vertex lighting core
//
// usage
// - a request (one packed normal plus its batch_end flag) is taken on any rising edge
//   where start is high and busy is low; busy never rises, so one request per cycle
// - each result (colour, shadow, batch_end copy) appears for exactly one cycle with
//   done_o high; results keep request order
// - throughput 1 request per cycle, through the five register stages:
//   expand/offset, light dot products, pair sum and facing factor, shading products,
//   wrapping sum and clamp
// - the receiver cannot stall; results leave on done_o whether or not anyone looks
// - configuration: cfg_valid_i/cfg_ready_o write channel, cfg_ready_o always high;
//   seven 64-bit registers of four 16-bit lanes, an index beyond them is ignored;
//   registers are read live, so write them only while no request is in flight
// - reset (rst_ni low, asynchronous) empties the pipeline and clears all configuration
//   registers to zero
module directional_vertex_lighting_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [31:0]                   normal_word_i,
  input  logic                          batch_end_i,
  // result channel
  output logic                          done_o,
  output logic [31:0]                   lit_rgba_o,
  output logic [31:0]                   shadow_rgba_o,
  output logic                          batch_end_out_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dvl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dvl_pkg::CfgW-1:0]      cfg_data_i
);

  localparam int unsigned LW = dvl_pkg::LaneW;
  localparam int unsigned NL = dvl_pkg::NLanes;
  localparam int unsigned DP = dvl_pkg::Depth;

  // configuration registers
  logic [dvl_pkg::CfgW-1:0] offset_q, light_q, ambient_q, lit_q, incident_q, shade_q, transl_q;

  logic accept;
  logic cfg_write;

  // nothing ever holds a request off
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      light_q    <= '0;
      ambient_q  <= '0;
      lit_q      <= '0;
      incident_q <= '0;
      shade_q    <= '0;
      transl_q   <= '0;
    end else if (cfg_write) begin
      case (dvl_pkg::dvl_cfg_e'(cfg_index_i))
        dvl_pkg::CfgNormalOffset:   offset_q   <= cfg_data_i;
        dvl_pkg::CfgLightDirection: light_q    <= cfg_data_i;
        dvl_pkg::CfgAmbientTerm:    ambient_q  <= cfg_data_i;
        dvl_pkg::CfgLitColor:       lit_q      <= cfg_data_i;
        dvl_pkg::CfgIncidentShadow: incident_q <= cfg_data_i;
        dvl_pkg::CfgBackShade:      shade_q    <= cfg_data_i;
        dvl_pkg::CfgTranslucent:    transl_q   <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // valid bits travel alongside the data, one per stage
  logic [DP-1:0] vld_d, vld_q;
  assign vld_d = {vld_q[DP-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // batch flag rides the same stages, no reset needed
  logic [DP-1:0] be_d, be_q;
  assign be_d = {be_q[DP-2:0], batch_end_i};

  always_ff @(posedge clk_i) begin
    be_q <= be_d;
  end

  // stage 1: widen each byte to b*257 and subtract the offset lane
  logic [LW-1:0] x_d [NL];
  logic [LW-1:0] x_q [NL];

  // stage 2: signed products with the light direction
  logic signed [2*LW-1:0] dp_d [NL];
  logic signed [2*LW-1:0] dp_q [NL];

  for (genvar i = 0; i < NL; i++) begin : g_front
    assign x_d[i]  = {normal_word_i[8*i +: 8], normal_word_i[8*i +: 8]} - offset_q[LW*i +: LW];
    assign dp_d[i] = $signed(x_q[i]) * $signed(light_q[LW*i +: LW]);
  end

  always_ff @(posedge clk_i) begin
    x_q  <= x_d;
    dp_q <= dp_d;
  end

  // stage 3: 32-bit wrapping sum, shift by 15, split into facing factors
  logic [2*LW-1:0]      dot_sum;
  logic [LW-1:0]        s_fac;
  dvl_pkg::dvl_factor_t fac_d, fac_q;

  assign dot_sum = (dp_q[0] + dp_q[1]) + (dp_q[2] + dp_q[3]);
  assign s_fac   = dot_sum[LW+14:15];

  always_comb begin
    if (s_fac[LW-1]) begin
      // back facing: no direct light, negative factor from the inverted value
      fac_d.pos = '0;
      fac_d.neg = ~s_fac;
    end else begin
      fac_d.pos = s_fac;
      fac_d.neg = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    fac_q <= fac_d;
  end

  // stages 4 and 5 live in the lane units: products, then sum and clamp
  for (genvar i = 0; i < NL; i++) begin : g_lane
    dvl_shade_lane u_colour (
      .clk_i      (clk_i),
      .factor_i   (fac_q),
      .ambient_i  (ambient_q[LW*i +: LW]),
      .coef_pos_i (lit_q[LW*i +: LW]),
      .coef_neg_i (transl_q[LW*i +: LW]),
      .byte_o     (lit_rgba_o[8*i +: 8])
    );

    dvl_shade_lane u_shadow (
      .clk_i      (clk_i),
      .factor_i   (fac_q),
      .ambient_i  (ambient_q[LW*i +: LW]),
      .coef_pos_i (incident_q[LW*i +: LW]),
      .coef_neg_i (shade_q[LW*i +: LW]),
      .byte_o     (shadow_rgba_o[8*i +: 8])
    );
  end

  assign done_o          = vld_q[DP-1];
  assign batch_end_out_o = be_q[DP-1];

  // every taken request comes out as a result on done_o
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("request did not produce a result after five cycles");

  // no result without a matching earlier request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 5))
    else $error("result strobe without matching request");

  // batch flag stays with its vertex
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (batch_end_out_o == $past(batch_end_i, 5)))
    else $error("batch_end flag out of step with its vertex");

endmodule
